// ----- src/lag_pkg.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid package
// Shared constants for the toroidal life grid: default size, field widths, request codes and rule counts.
// ----------------------------------------------------------------------------
package lag_pkg;

  // Default edge length of the square grid.
  localparam int unsigned GRID_SIZE_DEF = 32;

  // Field widths of the stream payloads.
  localparam int unsigned KIND_W  = 2;
  localparam int unsigned COORD_W = 5;

  // Request kinds.
  localparam logic [KIND_W-1:0] REQ_WRITE   = 2'd0;
  localparam logic [KIND_W-1:0] REQ_ADVANCE = 2'd1;
  localparam logic [KIND_W-1:0] REQ_READ    = 2'd2;

  // Neighbour counts of the B3/S23 rule.
  localparam logic [3:0] BIRTH_COUNT = 4'd3;
  localparam logic [3:0] KEEP_COUNT  = 4'd2;

endpackage

// ----- src/lag_row_cell.sv -----
// ----------------------------------------------------------------------------
// Life grid row cell
// Holds one grid row and passes it on to its neighbour while the ring turns.
// ----------------------------------------------------------------------------
module lag_row_cell #(
  parameter int unsigned Width = 32
) (
  input  logic             clk_i,
  input  logic             rst_ni,
  input  logic             shift_i,
  input  logic [Width-1:0] row_i,
  output logic [Width-1:0] row_o
);

  logic [Width-1:0] row_q;

  // The whole grid starts dead, so the stored row is cleared at reset.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      row_q <= '0;
    end else if (shift_i) begin
      row_q <= row_i;
    end
  end

  assign row_o = row_q;

endmodule

// ----- src/lag_rule_lane.sv -----
// ----------------------------------------------------------------------------
// Life rule lane
// Counts the eight neighbours of one cell and applies the B3/S23 rule.
// ----------------------------------------------------------------------------
module lag_rule_lane (
  input  logic [2:0] up_i,   // left, centre, right of the row above
  input  logic [2:0] mid_i,  // left, the cell itself, right
  input  logic [2:0] dn_i,   // left, centre, right of the row below
  output logic       alive_o
);

  import lag_pkg::*;

  logic [3:0] count;

  always_comb begin
    count = {3'b000, up_i[0]} + {3'b000, up_i[1]} + {3'b000, up_i[2]}
          + {3'b000, mid_i[0]} + {3'b000, mid_i[2]}
          + {3'b000, dn_i[0]} + {3'b000, dn_i[1]} + {3'b000, dn_i[2]};
  end

  assign alive_o = (count == BIRTH_COUNT) || (mid_i[1] && (count == KEEP_COUNT));

endmodule

// ----- src/life_automaton_grid_unit.sv -----
// ----------------------------------------------------------------------------
// Life automaton grid unit
// Toroidal B3/S23 life grid held in a ring of row cells, one row per cycle.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the s_axis channel. Each transfer carries a request
// kind (write a cell, advance one generation, read a cell), a row, a column
// and a cell value. Every request returns exactly one result transfer on the
// m_axis channel, echoing the kind and giving the cell value for reads.
// The grid rows sit in a ring of GridSize row cells. Every request turns the
// ring once, one row per cycle, and its result is presented when the turn
// ends; the single row rule unit at the head of the ring computes each row.
// A new request is taken only once the ring has come to rest, so the block
// does not take a new request before it is through with the last one.
// The result sits in an output register, so a new request may be taken while
// the previous result still waits. If the receiver stalls, the block finishes
// the turn and then holds until the output register is free.
// Reset clears every cell of the grid at once and empties the output register.
// Coordinates at or beyond GridSize are ignored by writes and read as zero.
// ----------------------------------------------------------------------------
module life_automaton_grid_unit #(
  parameter int unsigned GridSize = lag_pkg::GRID_SIZE_DEF
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  // tdata: [1:0] req_type, [6:2] cell_row, [11:7] cell_col, [12] cell_value
  input  logic [15:0] s_axis_tdata,
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // tdata: [1:0] done_kind, [2] read_value
  output logic [7:0]  m_axis_tdata
);

  import lag_pkg::*;

  localparam int unsigned IW = $clog2(GridSize);
  localparam int unsigned CW = (IW > COORD_W) ? IW : COORD_W;

  typedef enum logic [2:0] {
    ST_IDLE = 3'b001,
    ST_RUN  = 3'b010,
    ST_HOLD = 3'b100
  } state_e;

  state_e state_q, state_d;

  logic [IW-1:0]      step_q, step_d;
  logic [KIND_W-1:0]  kind_q;
  logic [COORD_W-1:0] row_q;
  logic [COORD_W-1:0] col_q;
  logic               val_q;
  logic               rd_q, rd_d;
  logic               out_valid_q, out_valid_d;
  logic [KIND_W-1:0]  out_kind_q;
  logic               out_rd_q;

  logic [GridSize-1:0] prev_q;   // old value of the row processed last cycle
  logic [GridSize-1:0] first_q;  // old value of row zero, needed by the last row

  logic [GridSize-1:0] row_w [GridSize];
  logic [GridSize-1:0] up_row, cur_row, dn_row;
  logic [GridSize-1:0] life_row, new_row;

  logic          accept;
  logic          shift;
  logic          last_step;
  logic          hit;
  logic          slot_free;
  logic [CW-1:0] col_x;
  logic [IW-1:0] col_idx;

  assign accept    = s_axis_tvalid && s_axis_tready;
  assign shift     = (state_q == ST_RUN);
  assign last_step = (step_q == IW'(GridSize - 1));
  assign slot_free = !out_valid_q || m_axis_tready;

  // The addressed row passes the head of the ring when the step count
  // equals its index; out-of-grid coordinates never match.
  assign col_x   = CW'(col_q);
  assign col_idx = col_x[IW-1:0];
  assign hit     = (32'(row_q) == 32'(step_q)) && (32'(col_q) < 32'(GridSize));

  // Ring of row cells: each takes its upper neighbour's row, the tail takes
  // the freshly computed row.
  for (genvar k = 0; k < GridSize; k++) begin : g_ring
    logic [GridSize-1:0] feed;
    if (k == GridSize - 1) begin : g_tail
      assign feed = new_row;
    end else begin : g_body
      assign feed = row_w[k+1];
    end
    lag_row_cell #(
      .Width (GridSize)
    ) u_row_cell (
      .clk_i  (clk_i),
      .rst_ni (rst_ni),
      .shift_i(shift),
      .row_i  (feed),
      .row_o  (row_w[k])
    );
  end

  // At step t the head holds old row t and its successor old row t+1. The
  // row above is kept aside, since the tail already holds new values, and
  // the last row wraps round to the saved copy of old row zero.
  assign cur_row = row_w[0];
  assign up_row  = (step_q == '0) ? row_w[GridSize-1] : prev_q;
  assign dn_row  = last_step ? first_q : row_w[1];

  for (genvar c = 0; c < GridSize; c++) begin : g_lane
    localparam int unsigned Lf = (c + GridSize - 1) % GridSize;
    localparam int unsigned Rt = (c + 1) % GridSize;
    lag_rule_lane u_rule_lane (
      .up_i   ({up_row[Rt],  up_row[c],  up_row[Lf]}),
      .mid_i  ({cur_row[Rt], cur_row[c], cur_row[Lf]}),
      .dn_i   ({dn_row[Rt],  dn_row[c],  dn_row[Lf]}),
      .alive_o(life_row[c])
    );
  end

  always_comb begin
    new_row = cur_row;
    rd_d    = rd_q;
    case (kind_q)
      REQ_ADVANCE: begin
        new_row = life_row;
      end
      REQ_WRITE: begin
        if (hit) begin
          new_row[col_idx] = val_q;
        end
      end
      REQ_READ: begin
        if (hit) begin
          rd_d = cur_row[col_idx];
        end
      end
      default: begin
      end
    endcase
  end

  // Sequencer: one full turn of the ring per request.
  always_comb begin
    state_d     = state_q;
    step_d      = step_q;
    out_valid_d = out_valid_q && !m_axis_tready;
    unique case (state_q)
      ST_IDLE: begin
        if (accept) begin
          state_d = ST_RUN;
        end
      end
      ST_RUN: begin
        if (last_step) begin
          step_d = '0;
          if (slot_free) begin
            out_valid_d = 1'b1;
            state_d     = ST_IDLE;
          end else begin
            state_d = ST_HOLD;
          end
        end else begin
          step_d = step_q + IW'(1);
        end
      end
      ST_HOLD: begin
        if (slot_free) begin
          out_valid_d = 1'b1;
          state_d     = ST_IDLE;
        end
      end
      default: begin
        state_d = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q     <= ST_IDLE;
      step_q      <= '0;
      out_valid_q <= 1'b0;
    end else begin
      state_q     <= state_d;
      step_q      <= step_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (accept) begin
      kind_q <= s_axis_tdata[1:0];
      row_q  <= s_axis_tdata[6:2];
      col_q  <= s_axis_tdata[11:7];
      val_q  <= s_axis_tdata[12];
      rd_q   <= 1'b0;
    end else if (shift) begin
      rd_q <= rd_d;
    end
    if (shift) begin
      prev_q <= cur_row;
      if (step_q == '0) begin
        first_q <= cur_row;
      end
    end
    if (!out_valid_d || (out_valid_q && !m_axis_tready)) begin
      // Output register holds its value while it waits or stays empty.
    end else begin
      out_kind_q <= kind_q;
      out_rd_q   <= (shift && last_step) ? rd_d : rd_q;
    end
  end

  assign s_axis_tready = (state_q == ST_IDLE);
  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tdata  = {5'b00000, out_rd_q, out_kind_q};

  // No request is taken while the ring is turning or a finished turn waits for the output register.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q == ST_RUN || state_q == ST_HOLD) |-> !s_axis_tready)
    else $error("request taken while the ring is busy");

  // An accepted request always starts a turn of the ring.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept |=> (state_q == ST_RUN && step_q == '0))
    else $error("accepted request did not start a turn");

  // A result appears only at the end of a turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    $rose(m_axis_tvalid) |-> ($past(state_q) == ST_HOLD ||
                              ($past(state_q) == ST_RUN && $past(last_step))))
    else $error("result presented before the turn finished");

  // The step count rests at zero outside a turn.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    (state_q != ST_RUN) |-> (step_q == '0))
    else $error("step count not at rest outside a turn");

endmodule
